// ----- design/segment_intersection_test_assert.svh -----
// ----------------------------------------------------------------------------
// Segment intersection test - assertion macros
// Shared wrappers for the concurrent checks on the segment test ports.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SIT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SIT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/sit_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test - package
// Flag groups that travel down the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Endpoint-containment and coincidence flags, formed in the first stage.
  // contained[0]: B start strictly inside A   contained[1]: B end strictly inside A
  // contained[2]: A start strictly inside B   contained[3]: A end strictly inside B
  typedef struct packed {
    logic [3:0] contained;
    logic [3:0] same;
  } geom_t;

  // Bit positions in geom_t.same
  localparam int SAME_AS_BS = 0;
  localparam int SAME_AS_BE = 1;
  localparam int SAME_AE_BS = 2;
  localparam int SAME_AE_BE = 3;

  // Sign of the four cross products: zero, or negative when not zero.
  typedef struct packed {
    logic [3:0] zero;
    logic [3:0] neg;
  } orient_t;

endpackage

// ----- design/segment_intersection_test.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle; the four register stages (differences,
// multipliers, cross-product sign, decision) each pass one item per cycle.
// Backpressure stalls only the stages that hold an item; bubbles still fill.
// Reset: rst clears every stage valid bit; no result is pending afterwards.
// ----------------------------------------------------------------------------
// Segment intersection test
// Exact orientation test of two segments with collinear and exact-match cases.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
  parameter int COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // tdata, low bit up: seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
  // seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y (COORD_BITS each)
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // tdata, low bit up: intersects, exact_match, six zero bits
  output logic [7:0]              m_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready
);

  localparam int C = COORD_BITS;
  localparam int D = C + 1;   // coordinate difference
  localparam int P = 2 * D;   // product of two differences
  localparam int S = P + 1;   // cross product

  typedef logic signed [C-1:0] coord_t;
  typedef logic signed [D-1:0] diff_t;
  typedef logic signed [P-1:0] prod_t;
  typedef logic signed [S-1:0] cross_t;

  function automatic logic axis_in(input coord_t q, input coord_t p, input coord_t r);
    logic all_eq;
    logic between;
    all_eq  = (q == p) && (q == r);
    between = ((q > p) && (q < r)) || ((q > r) && (q < p));
    return all_eq || between;
  endfunction

  // Point q strictly inside segment p-r
  function automatic logic pt_in(input coord_t qx, input coord_t qy, input coord_t px,
                                 input coord_t py, input coord_t rx, input coord_t ry);
    logic at_end;
    at_end = ((qx == px) && (qy == py)) || ((qx == rx) && (qy == ry));
    return !at_end && axis_in(qx, px, rx) && axis_in(qy, py, ry);
  endfunction

  // Unpack the item
  coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  assign ax0 = coord_t'(s_axis_tdata[0*C +: C]);
  assign ay0 = coord_t'(s_axis_tdata[1*C +: C]);
  assign ax1 = coord_t'(s_axis_tdata[2*C +: C]);
  assign ay1 = coord_t'(s_axis_tdata[3*C +: C]);
  assign bx0 = coord_t'(s_axis_tdata[4*C +: C]);
  assign by0 = coord_t'(s_axis_tdata[5*C +: C]);
  assign bx1 = coord_t'(s_axis_tdata[6*C +: C]);
  assign by1 = coord_t'(s_axis_tdata[7*C +: C]);

  // Stage valid bits and per-stage ready
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  assign rdy4 = !v4 || m_axis_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Orientation k uses segment k/2 as p-q; r is the far point of the test.
  coord_t rx_c [4];
  coord_t ry_c [4];
  coord_t qx_c [4];
  coord_t qy_c [4];
  sit_pkg::geom_t geom_c;

  always_comb begin
    qx_c[0] = ax1; qy_c[0] = ay1; rx_c[0] = bx0; ry_c[0] = by0;
    qx_c[1] = ax1; qy_c[1] = ay1; rx_c[1] = bx1; ry_c[1] = by1;
    qx_c[2] = bx1; qy_c[2] = by1; rx_c[2] = ax0; ry_c[2] = ay0;
    qx_c[3] = bx1; qy_c[3] = by1; rx_c[3] = ax1; ry_c[3] = ay1;

    geom_c.contained[0] = pt_in(bx0, by0, ax0, ay0, ax1, ay1);
    geom_c.contained[1] = pt_in(bx1, by1, ax0, ay0, ax1, ay1);
    geom_c.contained[2] = pt_in(ax0, ay0, bx0, by0, bx1, by1);
    geom_c.contained[3] = pt_in(ax1, ay1, bx0, by0, bx1, by1);
    geom_c.same[sit_pkg::SAME_AS_BS] = (ax0 == bx0) && (ay0 == by0);
    geom_c.same[sit_pkg::SAME_AS_BE] = (ax0 == bx1) && (ay0 == by1);
    geom_c.same[sit_pkg::SAME_AE_BS] = (ax1 == bx0) && (ay1 == by0);
    geom_c.same[sit_pkg::SAME_AE_BE] = (ax1 == bx1) && (ay1 == by1);
  end

  diff_t seg_dx1 [2];
  diff_t seg_dy1 [2];
  diff_t far_dx1 [4];
  diff_t far_dy1 [4];
  sit_pkg::geom_t geom1;

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      seg_dx1[0] <= $signed({ax1[C-1], ax1}) - $signed({ax0[C-1], ax0});
      seg_dy1[0] <= $signed({ay1[C-1], ay1}) - $signed({ay0[C-1], ay0});
      seg_dx1[1] <= $signed({bx1[C-1], bx1}) - $signed({bx0[C-1], bx0});
      seg_dy1[1] <= $signed({by1[C-1], by1}) - $signed({by0[C-1], by0});
      for (int k = 0; k < 4; k++) begin
        far_dx1[k] <= $signed({rx_c[k][C-1], rx_c[k]}) - $signed({qx_c[k][C-1], qx_c[k]});
        far_dy1[k] <= $signed({ry_c[k][C-1], ry_c[k]}) - $signed({qy_c[k][C-1], qy_c[k]});
      end
      geom1 <= geom_c;
    end
  end

  // ---------------------------------------------------------------- stage 2
  prod_t prod_a2 [4];
  prod_t prod_b2 [4];
  sit_pkg::geom_t geom2;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int k = 0; k < 4; k++) begin
        prod_a2[k] <= seg_dy1[k/2] * far_dx1[k];
        prod_b2[k] <= seg_dx1[k/2] * far_dy1[k];
      end
      geom2 <= geom1;
    end
  end

  // ---------------------------------------------------------------- stage 3
  cross_t cross_c [4];
  sit_pkg::orient_t ori3;
  sit_pkg::geom_t geom3;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cross_c[k] = $signed({prod_a2[k][P-1], prod_a2[k]})
                 - $signed({prod_b2[k][P-1], prod_b2[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int k = 0; k < 4; k++) begin
        ori3.zero[k] <= (cross_c[k] == '0);
        ori3.neg[k]  <= cross_c[k][S-1];
      end
      geom3 <= geom2;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic any_zero, col_hit, ends_match, exact_c, hit_c;
  logic intersects, exact_match;

  always_comb begin
    any_zero   = |ori3.zero;
    col_hit    = |(ori3.zero & geom3.contained);
    ends_match = (geom3.same[sit_pkg::SAME_AS_BS] || geom3.same[sit_pkg::SAME_AS_BE])
              && (geom3.same[sit_pkg::SAME_AE_BS] || geom3.same[sit_pkg::SAME_AE_BE]);
    exact_c    = any_zero && !col_hit && !(|geom3.contained) && ends_match;
    if (any_zero) begin
      hit_c = col_hit || exact_c;
    end else begin
      hit_c = (ori3.neg[0] ^ ori3.neg[1]) && (ori3.neg[2] ^ ori3.neg[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      intersects  <= hit_c;
      exact_match <= exact_c;
    end
  end

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = {6'b0, exact_match, intersects};

endmodule

// ----- design/sit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test - port checker
// Watches the stream ports of the segment test over time.
// ----------------------------------------------------------------------------
`include "segment_intersection_test_assert.svh"

module sit_checker #(
  parameter int COORD_BITS = 32
) (
  input logic                    clk,
  input logic                    rst,
  input logic [8*COORD_BITS-1:0] s_axis_tdata,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic [7:0]              m_axis_tdata,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready
);

  logic in_stall, out_stall, exact_no_hit;
  assign in_stall     = s_axis_tvalid && !s_axis_tready;
  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign exact_no_hit = m_axis_tdata[1] && !m_axis_tdata[0];

  `SIT_ASSERT(a_out_hold, clk, rst, out_stall |=> m_axis_tvalid, "result dropped while stalled")
  `SIT_ASSERT(a_out_stable, clk, rst, out_stall |=> $stable(m_axis_tdata), "result changed")
  `SIT_ASSERT(a_in_stable, clk, rst, in_stall |=> $stable(s_axis_tdata), "input item changed")
  `SIT_ASSERT(a_exact_hit, clk, rst, m_axis_tvalid |-> !exact_no_hit, "exact match without hit")
  `SIT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result pending after reset")

endmodule

bind segment_intersection_test sit_checker #(.COORD_BITS(COORD_BITS)) u_sit_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ----- bench/tb_segment_intersection_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection test - testbench
// Streams segment pairs into the block under random source and sink stalls,
// predicts the intersect and exact-match flags with exact wide cross
// products, and checks every result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test;

  localparam int COORD_BITS   = 32;
  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 2000;

  typedef enum int {
    PHASE_MIXED,
    PHASE_SWAPPED,
    PHASE_FULL_RATE
  } phase_t;

  typedef enum logic [1:0] {
    TURN_NONE,
    TURN_LEFT,
    TURN_RIGHT
  } turn_t;

  // Idle percentages per phase
  localparam int SEND_IDLE_PCT [3] = '{38, 51, 0};
  localparam int RECV_IDLE_PCT [3] = '{51, 38, 0};

  // Last member sits in the lowest bits, so a_start.x lands at bit 0
  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } point_t;

  typedef struct packed {
    point_t b_end;
    point_t b_start;
    point_t a_end;
    point_t a_start;
  } seg_pair_t;

  typedef struct packed {
    logic exact_match;
    logic intersects;
  } verdict_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic [8*COORD_BITS-1:0] s_axis_tdata = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              m_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;

  seg_pair_t pending_pairs [$];
  verdict_t  verdicts_due [$];
  int        n_items = 0;
  int        sent_cnt = 0;
  int        fail_cnt = 0;
  int        stall_cycles = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  phase_t    phase;

  segment_intersection_test #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic turn_t turn_of(point_t p, point_t q, point_t r);
    logic signed [127:0] dy1, dx1, dx2, dy2, cp;
    dy1 = $signed(q.y) - $signed(p.y);
    dx2 = $signed(r.x) - $signed(q.x);
    dx1 = $signed(q.x) - $signed(p.x);
    dy2 = $signed(r.y) - $signed(q.y);
    cp = dy1 * dx2 - dx1 * dy2;
    if (cp == 0) return TURN_NONE;
    return cp < 0 ? TURN_RIGHT : TURN_LEFT;
  endfunction

  function automatic bit axis_between(logic signed [COORD_BITS-1:0] q,
                                      logic signed [COORD_BITS-1:0] p,
                                      logic signed [COORD_BITS-1:0] r);
    logic signed [COORD_BITS-1:0] lo, hi;
    lo = (p < r) ? p : r;
    hi = (p < r) ? r : p;
    if (q == p && q == r) return 1'b1;
    return q > lo && q < hi;
  endfunction

  // q lies strictly inside segment p-r, shared endpoints excluded
  function automatic bit strictly_inside(point_t p, point_t q, point_t r);
    if (q == p || q == r) return 1'b0;
    return axis_between(q.x, p.x, r.x) && axis_between(q.y, p.y, r.y);
  endfunction

  function automatic verdict_t predict_verdict(seg_pair_t sp);
    turn_t    o1, o2, o3, o4;
    bit       in1, in2, in3, in4;
    verdict_t v;
    o1  = turn_of(sp.a_start, sp.a_end, sp.b_start);
    o2  = turn_of(sp.a_start, sp.a_end, sp.b_end);
    o3  = turn_of(sp.b_start, sp.b_end, sp.a_start);
    o4  = turn_of(sp.b_start, sp.b_end, sp.a_end);
    in1 = strictly_inside(sp.a_start, sp.b_start, sp.a_end);
    in2 = strictly_inside(sp.a_start, sp.b_end, sp.a_end);
    in3 = strictly_inside(sp.b_start, sp.a_start, sp.b_end);
    in4 = strictly_inside(sp.b_start, sp.a_end, sp.b_end);
    v = '0;
    if (o1 == TURN_NONE || o2 == TURN_NONE || o3 == TURN_NONE || o4 == TURN_NONE) begin
      if ((o1 == TURN_NONE && in1) || (o2 == TURN_NONE && in2) ||
          (o3 == TURN_NONE && in3) || (o4 == TURN_NONE && in4)) begin
        v.intersects = 1'b1;
      end else if (!in1 && !in2 && !in3 && !in4 &&
                   (sp.a_start == sp.b_start || sp.a_start == sp.b_end) &&
                   (sp.a_end == sp.b_start || sp.a_end == sp.b_end)) begin
        v.intersects  = 1'b1;
        v.exact_match = 1'b1;
      end
    end else if (o1 != o2 && o3 != o4) begin
      v.intersects = 1'b1;
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
    seg_pair_t sp;
    sp.a_start = '{y: ay, x: ax};
    sp.a_end   = '{y: by, x: bx};
    sp.b_start = '{y: cy, x: cx};
    sp.b_end   = '{y: dy, x: dx};
    return sp;
  endfunction

  // Append one item to the send queue
  function automatic void add_pair(seg_pair_t sp);
    pending_pairs.insert(pending_pairs.size(), sp);
  endfunction

  function automatic int signed_rand(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // Small lattice so that collinear and touching cases come up often
  function automatic point_t grid_point(point_t origin, int scale);
    point_t p;
    p.x = origin.x + signed_rand(4) * scale;
    p.y = origin.y + signed_rand(4) * scale;
    return p;
  endfunction

  function automatic point_t line_point(point_t base, point_t step);
    point_t p;
    int k;
    k = signed_rand(3);
    p.x = base.x + k * step.x;
    p.y = base.y + k * step.y;
    return p;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t sp;
    point_t    origin, step, tmp;
    int        kind, scale;
    kind   = $urandom_range(99);
    scale  = 1 << $urandom_range(16);
    origin = '{y: signed_rand(1 << 28), x: signed_rand(1 << 28)};
    if (kind < 20) begin
      sp = {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 40) begin
      sp.a_start = grid_point(origin, scale);
      sp.a_end   = grid_point(origin, scale);
      sp.b_start = grid_point(origin, scale);
      sp.b_end   = grid_point(origin, scale);
    end else if (kind < 65) begin
      step = '{y: signed_rand(1 << 16), x: signed_rand(1 << 16)};
      case ($urandom_range(3))
        0: step.y = 0;
        1: step.x = 0;
        default: ;
      endcase
      sp.a_start = line_point(origin, step);
      sp.a_end   = line_point(origin, step);
      sp.b_start = line_point(origin, step);
      sp.b_end   = line_point(origin, step);
    end else if (kind < 80) begin
      sp.a_start = grid_point(origin, scale);
      sp.a_end   = grid_point(origin, scale);
      sp.b_start = sp.a_start;
      sp.b_end   = sp.a_end;
      case ($urandom_range(3))
        0: sp.b_end = grid_point(origin, scale);
        1: sp.b_start = grid_point(origin, scale);
        default: ;
      endcase
      if ($urandom_range(1)) begin
        tmp        = sp.b_start;
        sp.b_start = sp.b_end;
        sp.b_end   = tmp;
      end
    end else begin
      sp = make_pair(signed_rand(1 << 20), signed_rand(1 << 20),
                     signed_rand(1 << 20), signed_rand(1 << 20),
                     signed_rand(1 << 20), signed_rand(1 << 20),
                     signed_rand(1 << 20), signed_rand(1 << 20));
    end
    return sp;
  endfunction

  // ---------------------------------------------------------------- driver

  always_comb begin
    if (sent_cnt * 3 < n_items)          phase = PHASE_MIXED;
    else if (sent_cnt * 3 < 2 * n_items) phase = PHASE_SWAPPED;
    else                                 phase = PHASE_FULL_RATE;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts_due.insert(verdicts_due.size(),
                            predict_verdict(seg_pair_t'(s_axis_tdata)));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pairs.size() != 0 &&
            $urandom_range(99) >= SEND_IDLE_PCT[phase]) begin
          s_axis_tdata  <= pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[1:0]);
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %b", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        want = verdicts_due.pop_front();
        if (got.intersects !== want.intersects) begin
          $display("%0t: intersects mismatch, expected %0b, got %0b",
                   $time, want.intersects, got.intersects);
          fail_cnt++;
        end
        if (got.exact_match !== want.exact_match) begin
          $display("%0t: exact_match mismatch, expected %0b, got %0b",
                   $time, want.exact_match, got.exact_match);
          fail_cnt++;
        end
      end
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (phase == PHASE_FULL_RATE && !hold_done) begin
      // back up the pipeline while the source keeps pushing
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= RECV_IDLE_PCT[phase];
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    // all points coincide
    add_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    // proper crossing
    add_pair(make_pair(0, 0, 4, 4, 0, 4, 4, 0));
    // parallel, apart
    add_pair(make_pair(0, 0, 4, 0, 0, 1, 4, 1));
    // collinear overlap
    add_pair(make_pair(0, 0, 4, 0, 2, 0, 6, 0));
    // collinear, disjoint
    add_pair(make_pair(0, 0, 2, 0, 3, 0, 5, 0));
    // collinear, touching at one end only
    add_pair(make_pair(0, 0, 2, 0, 2, 0, 4, 0));
    // endpoint of B on the interior of A
    add_pair(make_pair(0, 0, 4, 0, 2, 0, 2, 3));
    // touching at one end, not collinear
    add_pair(make_pair(0, 0, 2, 2, 2, 2, 4, 0));
    // exact match, same and reversed direction
    add_pair(make_pair(1, 2, 7, 9, 1, 2, 7, 9));
    add_pair(make_pair(1, 2, 7, 9, 7, 9, 1, 2));
    // degenerate A inside B
    add_pair(make_pair(1, 1, 1, 1, 0, 0, 2, 2));
    // degenerate A on an endpoint of B
    add_pair(make_pair(2, 2, 2, 2, 0, 0, 2, 2));
    // degenerate both, apart
    add_pair(make_pair(3, 3, 3, 3, 5, 5, 5, 5));
    // extremes
    add_pair(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
    add_pair(make_pair(mx, mx, mx, mx, mx, mx, mx, mx));
    add_pair(make_pair(mn, mn, mn, mn, mn, mn, mn, mn));
    add_pair(make_pair(mn, mx, mx, mn, mn, mn, mx, mx));
    add_pair(make_pair(mn, mn, mx, mn, 0, mn, mx, mn));
    add_pair(make_pair(mn, 0, mx, 0, mn, 0, mx, 0));
    // vertical collinear, B contained in A, then A contained in B
    add_pair(make_pair(0, 0, 0, 4, 0, 1, 0, 2));
    add_pair(make_pair(0, 1, 0, 2, 0, 0, 0, 4));
    // near miss above the interior
    add_pair(make_pair(0, 0, 4, 0, 2, 1, 2, 5));
    // diagonal collinear overlap
    add_pair(make_pair(0, 0, 4, 4, 2, 2, 6, 6));
    // alternating bit patterns
    add_pair(make_pair(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                       32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                       32'haaaa_aaaa, 32'haaaa_aaaa));
    repeat (RANDOM_ITEMS) add_pair(random_pair());
    n_items = pending_pairs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/sit_pkg.sv
design/segment_intersection_test.sv
design/sit_checker.sv
bench/tb_segment_intersection_test.sv
